// File: rtl/core/tcvi_pkg.sv
package tcvi_pkg;

    localparam int SIZE_X_DEF = 64;
    localparam int SIZE_Y_DEF = 64;
    localparam int SIZE_Z_DEF = 64;

    localparam logic [2:0] CFG_ORIGIN_X = 3'd0;
    localparam logic [2:0] CFG_ORIGIN_Y = 3'd1;
    localparam logic [2:0] CFG_ORIGIN_Z = 3'd2;
    localparam logic [2:0] CFG_INV_X    = 3'd3;
    localparam logic [2:0] CFG_INV_Y    = 3'd4;
    localparam logic [2:0] CFG_INV_Z    = 3'd5;

    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    // saturate a wide signed value to 32 bits
    function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
        logic signed [31:0] r;
        if (v > 40'sd2147483647)
            r = 32'sh7fffffff;
        else if (v < -40'sd2147483648)
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

// File: rtl/core/tricubic_volume_interpolator.sv
// Tricubic Catmull-Rom interpolator over a voxel volume held in one
// memory with one write port and one read port. A write item (func 0) stores
// one voxel. A query item (func 1) maps its position into grid coordinates
// with one shared 33x24 multiplier, one axis at a time, then reads the 64
// clamped neighbors one at a time from the memory read port; each group of four
// x-neighbors is folded by a Catmull-Rom cubic on one shared 40x17 Horner
// multiplier (three multiply steps plus a finish step). Sixteen x-cubics,
// four y-cubics and one z-cubic run on that same unit. Busy is high
// throughout; the result appears on interp_value with done high for one
// cycle and must be taken then, since the receiver cannot stall the block.
// Voxels must be written before a query reads them.
module tricubic_volume_interpolator #(
    parameter int SIZE_X = tcvi_pkg::SIZE_X_DEF,
    parameter int SIZE_Y = tcvi_pkg::SIZE_Y_DEF,
    parameter int SIZE_Z = tcvi_pkg::SIZE_Z_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               func,
    input  logic [5:0]         voxel_x,
    input  logic [5:0]         voxel_y,
    input  logic [5:0]         voxel_z,
    input  logic signed [31:0] voxel_value,
    input  logic signed [31:0] pos_x,
    input  logic signed [31:0] pos_y,
    input  logic signed [31:0] pos_z,
    output logic               done,
    output logic signed [31:0] interp_value,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data
);

    localparam int XW = $clog2(SIZE_X);
    localparam int YW = $clog2(SIZE_Y);
    localparam int ZW = $clog2(SIZE_Z);
    localparam int AW = XW + YW + ZW;
    // packed {z, y, x} address spans a power of two per axis
    localparam int DEPTH = 1 << AW;

    // states
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_WRITE = 4'd1;
    localparam logic [3:0] S_GRID  = 4'd2;
    localparam logic [3:0] S_RADDR = 4'd3;
    localparam logic [3:0] S_RDATA = 4'd4;
    localparam logic [3:0] S_CSET  = 4'd5;
    localparam logic [3:0] S_CMUL  = 4'd6;
    localparam logic [3:0] S_CFIN  = 4'd7;
    localparam logic [3:0] S_DONE  = 4'd8;

    // cubic level codes
    localparam logic [1:0] LV_X = 2'd0;
    localparam logic [1:0] LV_Y = 2'd1;
    localparam logic [1:0] LV_Z = 2'd2;

    logic [3:0] state_reg, state_next;

    // configuration
    logic signed [31:0] origin_reg [3];
    logic [23:0]        inv_reg [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                origin_reg[i] <= '0;
                inv_reg[i]    <= 24'd65536;
            end
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                tcvi_pkg::CFG_ORIGIN_X: origin_reg[0] <= cfg_data;
                tcvi_pkg::CFG_ORIGIN_Y: origin_reg[1] <= cfg_data;
                tcvi_pkg::CFG_ORIGIN_Z: origin_reg[2] <= cfg_data;
                tcvi_pkg::CFG_INV_X:    inv_reg[0] <= cfg_data[23:0];
                tcvi_pkg::CFG_INV_Y:    inv_reg[1] <= cfg_data[23:0];
                tcvi_pkg::CFG_INV_Z:    inv_reg[2] <= cfg_data[23:0];
                default: ;
            endcase
        end
    end

    // captured item
    logic               func_reg;
    logic [5:0]         wx_reg, wy_reg, wz_reg;
    logic signed [31:0] wval_reg;
    logic signed [31:0] pos_reg [3];

    // grid results per axis
    logic signed [25:0] idx_reg [3];
    logic [15:0]        t_reg [3];

    // counters
    logic [1:0] axis_reg;
    logic [5:0] nb_reg;     // neighbor counter: {z, y, x}
    logic [1:0] lv_reg;
    logic [3:0] cidx_reg;   // which cubic within level
    logic [1:0] hstep_reg;

    // operand buffers
    logic signed [31:0] px_reg [4];
    logic signed [31:0] ty_reg [16];   // x-cubic results at {z, y}
    logic signed [31:0] tz_reg [4];

    // horner state
    logic signed [39:0] h_reg;
    logic signed [39:0] b1_reg, b2_reg;
    logic signed [31:0] p1_reg;

    // memory
    logic [31:0]   mem [DEPTH];
    logic [31:0]   rdata_reg;
    logic [AW-1:0] raddr;
    logic          mem_we;
    logic [AW-1:0] waddr;

    // ---------- grid multiply, one axis a cycle
    logic signed [32:0] rel;
    logic signed [57:0] gprod;
    assign rel   = 33'(pos_reg[axis_reg]) - 33'(origin_reg[axis_reg]);
    assign gprod = 58'(rel) * $signed({34'd0, inv_reg[axis_reg]});

    // ---------- neighbor index clamping
    function automatic logic [7:0] clampi(input logic signed [25:0] c,
                                          input int size);
        logic [7:0] r;
        if (c < 0)
            r = '0;
        else if (c > 26'(size - 1))
            r = 8'(size - 1);
        else
            r = c[7:0];
        return r;
    endfunction

    logic signed [25:0] cx, cy, cz;
    logic [7:0] ix, iy, iz;
    assign cx = idx_reg[0] + 26'(nb_reg[1:0]) - 26'sd1;
    assign cy = idx_reg[1] + 26'(nb_reg[3:2]) - 26'sd1;
    assign cz = idx_reg[2] + 26'(nb_reg[5:4]) - 26'sd1;
    assign ix = clampi(cx, SIZE_X);
    assign iy = clampi(cy, SIZE_Y);
    assign iz = clampi(cz, SIZE_Z);

    // ---------- cubic operand selection
    logic signed [31:0] q0, q1, q2, q3;
    logic [15:0] tsel;
    always_comb
    begin
        unique case (lv_reg)
            LV_X:
            begin
                q0 = px_reg[0]; q1 = px_reg[1]; q2 = px_reg[2]; q3 = px_reg[3];
                tsel = t_reg[0];
            end
            LV_Y:
            begin
                // walk y for the z plane given by cidx
                q0 = ty_reg[{cidx_reg[1:0], 2'd0}];
                q1 = ty_reg[{cidx_reg[1:0], 2'd1}];
                q2 = ty_reg[{cidx_reg[1:0], 2'd2}];
                q3 = ty_reg[{cidx_reg[1:0], 2'd3}];
                tsel = t_reg[1];
            end
            default:
            begin
                q0 = tz_reg[0]; q1 = tz_reg[1]; q2 = tz_reg[2]; q3 = tz_reg[3];
                tsel = t_reg[2];
            end
        endcase
    end

    logic signed [39:0] e0, e1, e2, e3;
    logic signed [39:0] cb1, cb2, cb3;
    assign e0  = 40'(q0);
    assign e1  = 40'(q1);
    assign e2  = 40'(q2);
    assign e3  = 40'(q3);
    assign cb1 = e2 - e0;
    assign cb2 = -e3 + (e2 <<< 2) - ((e1 <<< 2) + e1) + (e0 <<< 1);
    assign cb3 = e3 - ((e2 <<< 1) + e2) + ((e1 <<< 1) + e1) - e0;

    // shared horner multiplier: floor((h * t) / 2^16)
    logic signed [56:0] hprod;
    logic signed [39:0] hsh;
    assign hprod = 57'(h_reg) * $signed({41'd0, tsel});
    assign hsh   = 40'(hprod >>> 16);

    logic signed [31:0] cres;
    assign cres = tcvi_pkg::sat32((h_reg >>> 1) + 40'(p1_reg));

    assign waddr  = {ZW'(wz_reg), YW'(wy_reg), XW'(wx_reg)};
    assign mem_we = (state_reg == S_WRITE)
                    && (int'(wx_reg) < SIZE_X) && (int'(wy_reg) < SIZE_Y)
                    && (int'(wz_reg) < SIZE_Z);

    // neighbor address follows nb_reg; data is registered in S_RADDR
    // and lands in px_reg at the end of S_RDATA
    assign raddr = {iz[ZW-1:0], iy[YW-1:0], ix[XW-1:0]};

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[waddr] <= wval_reg;
        rdata_reg <= mem[raddr];
    end

    // ---------- sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
                if (start)
                    state_next = (func == tcvi_pkg::FUNC_WRITE) ? S_WRITE : S_GRID;
            S_WRITE: state_next = S_IDLE;
            S_GRID:  if (axis_reg == 2'd2) state_next = S_RADDR;
            S_RADDR: state_next = S_RDATA;
            S_RDATA: state_next = (nb_reg[1:0] == 2'd3) ? S_CSET : S_RADDR;
            S_CSET:  state_next = S_CMUL;
            S_CMUL:  if (hstep_reg == 2'd2) state_next = S_CFIN;
            S_CFIN:
            begin
                priority if (lv_reg == LV_Z)
                    state_next = S_DONE;
                else if (lv_reg == LV_X && nb_reg == 6'd0)
                    state_next = S_CSET;
                else if (lv_reg == LV_X)
                    state_next = S_RADDR;
                else
                    state_next = S_CSET;
            end
            S_DONE:  state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            axis_reg  <= '0;
            nb_reg    <= '0;
            lv_reg    <= LV_X;
            cidx_reg  <= '0;
            hstep_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            unique case (state_reg)
                S_IDLE:
                begin
                    axis_reg <= '0;
                    nb_reg   <= '0;
                    lv_reg   <= LV_X;
                    cidx_reg <= '0;
                end
                S_GRID:  axis_reg <= axis_reg + 2'd1;
                S_RDATA: nb_reg <= nb_reg + 6'd1;
                S_CSET:  hstep_reg <= '0;
                S_CMUL:  hstep_reg <= hstep_reg + 2'd1;
                S_CFIN:
                begin
                    // level x ends after 16 cubics, y after 4
                    priority if (lv_reg == LV_X && cidx_reg == 4'd15)
                    begin
                        lv_reg   <= LV_Y;
                        cidx_reg <= '0;
                    end
                    else if (lv_reg == LV_Y && cidx_reg == 4'd3)
                    begin
                        lv_reg   <= LV_Z;
                        cidx_reg <= '0;
                    end
                    else
                        cidx_reg <= cidx_reg + 4'd1;
                end
                default: ;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && start)
        begin
            func_reg   <= func;
            wx_reg     <= voxel_x;
            wy_reg     <= voxel_y;
            wz_reg     <= voxel_z;
            wval_reg   <= voxel_value;
            pos_reg[0] <= pos_x;
            pos_reg[1] <= pos_y;
            pos_reg[2] <= pos_z;
        end
        if (state_reg == S_GRID)
        begin
            idx_reg[axis_reg] <= gprod[57:32];
            t_reg[axis_reg]   <= gprod[31:16];
        end
        if (state_reg == S_RDATA)
            px_reg[nb_reg[1:0]] <= rdata_reg;
        if (state_reg == S_CSET)
        begin
            h_reg  <= cb3;
            b2_reg <= cb2;
            b1_reg <= cb1;
            p1_reg <= q1;
        end
        if (state_reg == S_CMUL)
        begin
            unique case (hstep_reg)
                2'd0:    h_reg <= hsh + b2_reg;
                2'd1:    h_reg <= hsh + b1_reg;
                default: h_reg <= hsh;
            endcase
        end
        if (state_reg == S_CFIN)
        begin
            unique case (lv_reg)
                LV_X:    ty_reg[cidx_reg] <= cres;
                LV_Y:    tz_reg[cidx_reg[1:0]] <= cres;
                default: interp_value <= cres;
            endcase
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign done = (state_reg == S_DONE) && func_reg;

endmodule

// File: rtl/core/tcvi_checker.sv
module tcvi_checker (
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic func,
    input logic done
);

    a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after start");

    a_done_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy)
        else $error("done outside busy");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done held two cycles");

    a_write_no_done: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && !func) |=> ##1 !done)
        else $error("write item produced a result");

endmodule

bind tricubic_volume_interpolator tcvi_checker u_tcvi_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .func  (func),
    .done  (done)
);

// File: dv/tricubic_volume_interpolator_tb.sv
module tricubic_volume_interpolator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // volume edge; the random queries read only the low and high corner slabs of each axis
    localparam int VOL_N = 64;
    localparam int RANDOM_ITEMS = 1420;

    typedef enum logic [1:0] {
        STEP_ITEM,   // write or query item on the command port
        STEP_CFG,    // register write, only while the block is idle
        STEP_DRAIN   // hold off until every expected value has come back
    } step_kind_t;

    typedef struct {
        step_kind_t         kind;
        logic               fn;
        logic [5:0]         vx;
        logic [5:0]         vy;
        logic [5:0]         vz;
        logic signed [31:0] value;
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] pz;
        logic [2:0]         reg_idx;
        logic [31:0]        reg_data;
    } step_t;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic               func;
    logic [5:0]         voxel_x;
    logic [5:0]         voxel_y;
    logic [5:0]         voxel_z;
    logic signed [31:0] voxel_value;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic               done;
    logic signed [31:0] interp_value;
    logic               cfg_we;
    logic [2:0]         cfg_index;
    logic [31:0]        cfg_data;

    tricubic_volume_interpolator i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .func        (func),
        .voxel_x     (voxel_x),
        .voxel_y     (voxel_y),
        .voxel_z     (voxel_z),
        .voxel_value (voxel_value),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .pos_z       (pos_z),
        .done        (done),
        .interp_value(interp_value),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    // shared state between the stimulus, the driver and the result checker
    step_t              pending_steps[$];
    logic signed [31:0] expected_values[$];
    bit [31:0]          voxel_mirror[VOL_N*VOL_N*VOL_N];

    // predictor copy of the registers, updated when the driver writes them
    logic signed [31:0] origin_now[3];
    logic [23:0]        inv_now[3];
    // stimulus copy, updated as register writes are queued
    logic signed [31:0] origin_plan[3];
    logic [23:0]        inv_plan[3];

    int  n_accepted;
    int  n_writes;
    int  n_queries;
    int  n_settings;
    int  n_checked;
    int  n_errors;
    int  quiet_cycles;
    step_t cur_item;

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // ---------------------------------------------------------------
    // predictor
    // ---------------------------------------------------------------

    // grid coordinate on one axis: cell index and 16 bit fraction
    function automatic void grid_axis(input logic signed [31:0] p,
                                      input logic signed [31:0] o,
                                      input logic [23:0] s,
                                      output longint grid_idx, output longint frac);
        longint g;
        g = (longint'(p) - longint'(o)) * longint'(s);
        grid_idx = g >>> 32;
        frac = (g >>> 16) & 64'hFFFF;
    endfunction

    function automatic longint clamp_edge(input longint c);
        longint r;
        r = c;
        if (r < 0)
            r = 0;
        if (r > VOL_N - 1)
            r = VOL_N - 1;
        return r;
    endfunction

    // catmull-rom in horner form, floor shifts, saturated to 32 bits
    function automatic longint catmull_rom(input longint p0, input longint p1,
                                           input longint p2, input longint p3,
                                           input longint t);
        longint b1;
        longint b2;
        longint b3;
        longint h;
        b1 = p2 - p0;
        b2 = -p3 + 4 * p2 - 5 * p1 + 2 * p0;
        b3 = p3 - 3 * p2 + 3 * p1 - p0;
        h = ((b3 * t) >>> 16) + b2;
        h = ((h * t) >>> 16) + b1;
        h = (h * t) >>> 16;
        h = (h >>> 1) + p1;
        if (h > 64'sd2147483647)
            h = 64'sd2147483647;
        if (h < -64'sd2147483648)
            h = -64'sd2147483648;
        return h;
    endfunction

    function automatic longint voxel_at(input longint x, input longint y, input longint z);
        int unsigned a;
        a = int'((z * VOL_N + y) * VOL_N + x);
        return longint'($signed(voxel_mirror[a]));
    endfunction

    function automatic logic signed [31:0] interpolate_at(input logic signed [31:0] px,
                                                          input logic signed [31:0] py,
                                                          input logic signed [31:0] pz);
        longint cx, cy, cz, tx, ty, tz;
        longint xs[4];
        longint ys[4];
        longint zs[4];
        longint row[4][4];
        longint col[4];
        longint r;
        grid_axis(px, origin_now[0], inv_now[0], cx, tx);
        grid_axis(py, origin_now[1], inv_now[1], cy, ty);
        grid_axis(pz, origin_now[2], inv_now[2], cz, tz);
        for (int i = 0; i < 4; i++)
        begin
            xs[i] = clamp_edge(cx + i - 1);
            ys[i] = clamp_edge(cy + i - 1);
            zs[i] = clamp_edge(cz + i - 1);
        end
        // x pass over every (y, z) row, then y, then z
        for (int j = 0; j < 4; j++)
            for (int k = 0; k < 4; k++)
                row[j][k] = catmull_rom(voxel_at(xs[0], ys[j], zs[k]),
                                        voxel_at(xs[1], ys[j], zs[k]),
                                        voxel_at(xs[2], ys[j], zs[k]),
                                        voxel_at(xs[3], ys[j], zs[k]), tx);
        for (int k = 0; k < 4; k++)
            col[k] = catmull_rom(row[0][k], row[1][k], row[2][k], row[3][k], ty);
        r = catmull_rom(col[0], col[1], col[2], col[3], tz);
        return r[31:0];
    endfunction

    // an item accepted by the block updates the mirror or queues an answer
    function automatic void take_item(input step_t it);
        if (it.fn == tcvi_pkg::FUNC_WRITE)
        begin
            voxel_mirror[(int'(it.vz) * VOL_N + int'(it.vy)) * VOL_N + int'(it.vx)] = it.value;
            n_writes++;
        end
        else
        begin
            expected_values.push_back(interpolate_at(it.px, it.py, it.pz));
            n_queries++;
        end
        n_accepted++;
    endfunction

    // sender gap rate by phase of the run
    function automatic int gap_pct();
        int r;
        if (n_accepted < 700)
            r = 15;
        else if (n_accepted < 1500)
            r = 48;
        else
            r = 0;
        return r;
    endfunction

    // ---------------------------------------------------------------
    // driver
    // ---------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : drive_proc
        logic nxt_start;
        logic nxt_we;
        if (!rst_n)
        begin
            start        <= 1'b0;
            func         <= tcvi_pkg::FUNC_WRITE;
            voxel_x      <= '0;
            voxel_y      <= '0;
            voxel_z      <= '0;
            voxel_value  <= '0;
            pos_x        <= '0;
            pos_y        <= '0;
            pos_z        <= '0;
            cfg_we       <= 1'b0;
            cfg_index    <= tcvi_pkg::CFG_ORIGIN_X;
            cfg_data     <= '0;
            quiet_cycles <= 0;
        end
        else
        begin
            nxt_start = start;
            nxt_we = 1'b0;
            if (start && !busy)
            begin
                take_item(cur_item);
                nxt_start = 1'b0;
            end
            // idle time with nothing in flight, used before register writes
            if (!start && !busy)
                quiet_cycles <= quiet_cycles + 1;
            else
                quiet_cycles <= 0;
            if (!nxt_start && !cfg_we && pending_steps.size() > 0)
            begin
                case (pending_steps[0].kind)
                    STEP_ITEM:
                    begin
                        if ($urandom_range(99) >= gap_pct())
                        begin
                            cur_item = pending_steps.pop_front();
                            func        <= cur_item.fn;
                            voxel_x     <= cur_item.vx;
                            voxel_y     <= cur_item.vy;
                            voxel_z     <= cur_item.vz;
                            voxel_value <= cur_item.value;
                            pos_x       <= cur_item.px;
                            pos_y       <= cur_item.py;
                            pos_z       <= cur_item.pz;
                            nxt_start = 1'b1;
                        end
                    end
                    STEP_CFG:
                    begin
                        if (!start && !busy && expected_values.size() == 0
                            && quiet_cycles >= 4)
                        begin
                            cur_item = pending_steps.pop_front();
                            if (cur_item.reg_idx <= tcvi_pkg::CFG_ORIGIN_Z)
                                origin_now[cur_item.reg_idx] = cur_item.reg_data;
                            else
                                inv_now[cur_item.reg_idx - tcvi_pkg::CFG_INV_X] =
                                    cur_item.reg_data[23:0];
                            cfg_index <= cur_item.reg_idx;
                            cfg_data  <= cur_item.reg_data;
                            nxt_we = 1'b1;
                        end
                    end
                    default:
                    begin
                        if (!start && !busy && expected_values.size() == 0)
                            void'(pending_steps.pop_front());
                    end
                endcase
            end
            start  <= nxt_start;
            cfg_we <= nxt_we;
        end
    end

    // ---------------------------------------------------------------
    // result checker: every done pulse must match the oldest prediction
    // ---------------------------------------------------------------
    always @(posedge clk)
    begin : check_proc
        logic signed [31:0] want;
        if (rst_n && done)
        begin
            if (expected_values.size() == 0)
            begin
                $error("interp_value: unexpected result %0d", interp_value);
                n_errors++;
            end
            else
            begin
                want = expected_values.pop_front();
                if (interp_value !== want)
                begin
                    $error("interp_value: expected %0d actual %0d", want, interp_value);
                    n_errors++;
                end
                n_checked++;
            end
        end
    end

    // ---------------------------------------------------------------
    // stimulus
    // ---------------------------------------------------------------
    function automatic step_t blank_step(input step_kind_t k);
        step_t s;
        s.kind = k;
        s.fn = tcvi_pkg::FUNC_WRITE;
        s.vx = '0;
        s.vy = '0;
        s.vz = '0;
        s.value = '0;
        s.px = '0;
        s.py = '0;
        s.pz = '0;
        s.reg_idx = tcvi_pkg::CFG_ORIGIN_X;
        s.reg_data = '0;
        return s;
    endfunction

    function automatic void queue_write(input int x, input int y, input int z,
                                        input logic signed [31:0] v);
        step_t s;
        s = blank_step(STEP_ITEM);
        s.fn = tcvi_pkg::FUNC_WRITE;
        s.vx = x[5:0];
        s.vy = y[5:0];
        s.vz = z[5:0];
        s.value = v;
        pending_steps.push_back(s);
    endfunction

    function automatic void queue_query(input logic signed [31:0] px,
                                        input logic signed [31:0] py,
                                        input logic signed [31:0] pz);
        step_t s;
        s = blank_step(STEP_ITEM);
        s.fn = tcvi_pkg::FUNC_QUERY;
        s.px = px;
        s.py = py;
        s.pz = pz;
        // garbage in the write fields must not matter for a query
        s.vx = 6'($urandom);
        s.vy = 6'($urandom);
        s.vz = 6'($urandom);
        s.value = $urandom;
        pending_steps.push_back(s);
    endfunction

    // a full register set, written once the block has gone quiet
    function automatic void queue_setting(input logic signed [31:0] ox,
                                          input logic signed [31:0] oy,
                                          input logic signed [31:0] oz,
                                          input logic [23:0] sx, input logic [23:0] sy,
                                          input logic [23:0] sz);
        step_t s;
        logic [31:0] vals[6];
        logic [2:0] idxs[6];
        vals = '{ox, oy, oz, {8'd0, sx}, {8'd0, sy}, {8'd0, sz}};
        idxs = '{tcvi_pkg::CFG_ORIGIN_X, tcvi_pkg::CFG_ORIGIN_Y, tcvi_pkg::CFG_ORIGIN_Z,
                 tcvi_pkg::CFG_INV_X, tcvi_pkg::CFG_INV_Y, tcvi_pkg::CFG_INV_Z};
        pending_steps.push_back(blank_step(STEP_DRAIN));
        for (int i = 0; i < 6; i++)
        begin
            s = blank_step(STEP_CFG);
            s.reg_idx = idxs[i];
            s.reg_data = vals[i];
            pending_steps.push_back(s);
        end
        origin_plan = '{ox, oy, oz};
        inv_plan = '{sx, sy, sz};
        n_settings++;
    endfunction

    // cells whose four neighbors stay inside the written low or high slab
    function automatic bit cell_ok(input longint c);
        return (c <= 1) || (c >= VOL_N - 3);
    endfunction

    function automatic logic [31:0] edge_value();
        logic [31:0] v;
        case ($urandom_range(9))
            0: v = 32'h7fffffff;
            1: v = 32'h80000000;
            2: v = 32'h0;
            default: v = $urandom;
        endcase
        return v;
    endfunction

    // position on one axis that lands near a written slab (or far outside)
    function automatic logic signed [31:0] pick_axis(input int ax);
        longint grid_idx, frac, want, g, p;
        logic signed [31:0] r;
        bit ok;
        ok = 0;
        r = '0;
        while (!ok)
        begin
            if ($urandom_range(3) == 0 || inv_plan[ax] == 0)
            begin
                r = $urandom;
            end
            else
            begin
                want = $urandom_range(1) ? longint'($urandom_range(4)) - 3
                                         : longint'(VOL_N - 3 + $urandom_range(5));
                g = (want <<< 32) + longint'($urandom);
                p = longint'(origin_plan[ax]) + g / longint'(inv_plan[ax]);
                if (p > 64'sd2147483647 || p < -64'sd2147483648)
                    r = $urandom;
                else
                    r = p[31:0];
            end
            grid_axis(r, origin_plan[ax], inv_plan[ax], grid_idx, frac);
            ok = cell_ok(grid_idx);
        end
        return r;
    endfunction

    function automatic int slab_index();
        int r;
        r = $urandom_range(3);
        if ($urandom_range(1))
            r = r + VOL_N - 4;
        return r;
    endfunction

    initial
    begin : main_proc
        int waited;
        n_accepted = 0;
        n_writes = 0;
        n_queries = 0;
        n_settings = 0;
        n_checked = 0;
        n_errors = 0;
        origin_now = '{32'sd0, 32'sd0, 32'sd0};
        inv_now = '{24'd65536, 24'd65536, 24'd65536};
        origin_plan = origin_now;
        inv_plan = inv_now;

        rst_n = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // fill the low and high corner slabs so the random queries read written voxels;
        // the low corner gets alternating extremes to drive the cubics into saturation
        for (int z = 0; z < 8; z++)
            for (int y = 0; y < 8; y++)
                for (int x = 0; x < 8; x++)
                begin
                    int ix, iy, iz;
                    ix = (x < 4) ? x : x + VOL_N - 8;
                    iy = (y < 4) ? y : y + VOL_N - 8;
                    iz = (z < 4) ? z : z + VOL_N - 8;
                    if (ix < 4 && iy < 4 && iz < 4)
                        queue_write(ix, iy, iz, ((ix + iy + iz) % 2) ? 32'h7fffffff
                                                                     : 32'h80000000);
                    else
                        queue_write(ix, iy, iz, edge_value());
                end

        // directed queries at reset settings: grid unit is one Q16.16 unit
        queue_query(32'h0, 32'h0, 32'h0);                    // first cell, zero fraction
        queue_query(32'h0001ffff, 32'h0001ffff, 32'h0001ffff); // largest fraction
        queue_query(32'h00010000, 32'h00008000, 32'h0000c000);
        queue_query(32'h003e0000, 32'h003f0000, 32'h003d8000); // high edge cells
        queue_query(32'h7fffffff, 32'h7fffffff, 32'h7fffffff); // far outside, clamped high
        queue_query(32'h80000000, 32'h80000000, 32'h80000000); // far outside, clamped low
        queue_query(32'h80000000, 32'h7fffffff, 32'h00014000);
        queue_query(32'hffff8000, 32'h003e4000, 32'h80000000);
        // a write in the middle of the volume is legal even if never read
        queue_write(31, 17, 45, 32'h12345678);
        queue_write(63, 63, 63, 32'h7fffffff);
        queue_query(32'h003f0000, 32'h003f0000, 32'h003f0000);
        queue_write(0, 0, 0, 32'h80000000);
        queue_query(32'h0, 32'h00010000, 32'hffff0000);

        // zero inverse spacing pins an axis to cell zero
        queue_setting(32'sh00050000, -32'sh00030000, 32'sh0, 24'd0, 24'd65536, 24'd0);
        queue_query(32'h7fffffff, 32'h00018000, 32'h80000000);
        queue_query($urandom, 32'h003f0000, $urandom);

        // random part across several register settings, extremes among them
        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph)
                0: queue_setting(32'sh0, 32'sh0, 32'sh0, 24'd65536, 24'd65536, 24'd65536);
                1: queue_setting(32'sh7fffffff, 32'sh80000000, 32'sh7fffffff,
                                 24'hffffff, 24'hffffff, 24'hffffff);
                2: queue_setting(32'sh80000000, 32'sh7fffffff, 32'sh80000000,
                                 24'd1, 24'd1, 24'd1);
                default: queue_setting($urandom, $urandom, $urandom,
                                       24'($urandom_range(24'hffffff, 1)),
                                       24'($urandom_range(24'h3ffff, 1)),
                                       24'($urandom_range(24'hffffff, 1)));
            endcase
            for (int n = 0; n < RANDOM_ITEMS / 8; n++)
            begin
                if ($urandom_range(99) < 40)
                begin
                    if ($urandom_range(9) < 7)
                        queue_write(slab_index(), slab_index(), slab_index(), edge_value());
                    else
                        queue_write($urandom_range(63), $urandom_range(63),
                                    $urandom_range(63), edge_value());
                end
                else
                begin
                    queue_query(pick_axis(0), pick_axis(1), pick_axis(2));
                end
                // now and then let everything drain before moving on
                if ($urandom_range(99) == 0)
                    pending_steps.push_back(blank_step(STEP_DRAIN));
            end
        end

        while (pending_steps.size() > 0 || start)
            @(posedge clk);
        waited = 0;
        while ((expected_values.size() > 0 || busy) && waited < 2000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (300) @(posedge clk);
        if (expected_values.size() > 0)
        begin
            $error("interp_value: %0d expected results never came", expected_values.size());
            n_errors++;
        end

        $display("run covered %0d voxel writes and %0d queries over %0d register settings",
                 n_writes, n_queries, n_settings);
        $display("%0d results compared, %0d mismatches", n_checked, n_errors);
        if (n_errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // watchdog
    initial
    begin
        #50ms;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
